// ----- rtl/core/sll_pkg.sv -----
// shared widths, register codes and burst control type for the sound level light driver
package sll_pkg;

   localparam int BAND_W  = 8;
   localparam int LEVEL_W = 16;
   localparam int LIGHT_W = 8;
   localparam int OUT_SLOT_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SLOT_COUNT_W = 5;

   localparam logic [LIGHT_W-1:0] FULL_LIGHT = 8'd255;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIP_VALUE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_COUNT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_SELECT = 3'd4;

   // mode codes
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_FOLLOW = 2'd1;
   localparam logic [1:0] MODE_PEAK   = 2'd2;
   localparam logic [1:0] MODE_CHASE  = 2'd3;

   // values of the one or two segments of a burst
   typedef struct packed {
      logic               two_seg;
      logic [LIGHT_W-1:0] a_value;
      logic [LIGHT_W-1:0] b_value;
   } burst_ctrl_type;

endpackage

// ----- rtl/core/sll_req_if.sv -----
// request and response channel interfaces for the sound level light driver
interface sll_req_if import sll_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BAND_W-1:0]  band_index;
   logic [LEVEL_W-1:0] band_level;

   modport source (output valid, output band_index, output band_level, input ready);
   modport sink (input valid, input band_index, input band_level, output ready);
endinterface

interface sll_rsp_if import sll_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OUT_SLOT_W-1:0] slot;
   logic [LIGHT_W-1:0]    light_value;
   logic                  last_write;

   modport source (output valid, output slot, output light_value, output last_write,
                   input ready);
   modport sink (input valid, input slot, input light_value, input last_write,
                 output ready);
endinterface

// ----- rtl/core/sll_burst.sv -----
// burst sequencer: feeds one stored burst to the result register, a write per ready cycle
module sll_burst import sll_pkg::*; #(
   parameter int SLOT_W = 4,
   parameter int CNT_W  = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   output logic                load_ready,
   input  burst_ctrl_type      load_ctrl,
   input  logic [SLOT_W-1:0]   load_a_slot,
   input  logic [SLOT_W-1:0]   load_b_slot,
   input  logic [CNT_W-1:0]    load_span,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [SLOT_W-1:0]   out_slot,
   output logic [LIGHT_W-1:0]  out_value,
   output logic                out_last
);

   logic                desc_valid_ff, desc_valid_in;
   burst_ctrl_type      ctrl_ff;
   logic [SLOT_W-1:0]   a_slot_ff, b_slot_ff;
   logic [CNT_W-1:0]    span_ff;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic                seg_ff, seg_in;

   logic                out_valid_ff, out_valid_in;
   logic [SLOT_W-1:0]   out_slot_ff;
   logic [LIGHT_W-1:0]  out_value_ff;
   logic                out_last_ff;

   logic                issue, seg_end, burst_end, load;
   logic [SLOT_W-1:0]   cur_slot;
   logic [LIGHT_W-1:0]  cur_value;

   assign issue     = desc_valid_ff && (!out_valid_ff || out_ready);
   assign seg_end   = (CNT_W'(idx_ff) + CNT_W'(1)) == span_ff;
   assign burst_end = seg_end && (seg_ff || !ctrl_ff.two_seg);
   assign load_ready = !desc_valid_ff || (issue && burst_end);
   assign load      = load_valid && load_ready;
   assign cur_slot  = (seg_ff ? b_slot_ff : a_slot_ff) + idx_ff;
   assign cur_value = seg_ff ? ctrl_ff.b_value : ctrl_ff.a_value;

   always_comb begin
      desc_valid_in = desc_valid_ff;
      idx_in = idx_ff;
      seg_in = seg_ff;
      if (issue) begin
         if (seg_end) begin
            idx_in = '0;
            seg_in = 1'b1;
         end else begin
            idx_in = idx_ff + SLOT_W'(1);
         end
         if (burst_end) begin
            desc_valid_in = 1'b0;
         end
      end
      if (load) begin
         desc_valid_in = 1'b1;
         idx_in = '0;
         seg_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (issue) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         seg_ff        <= 1'b0;
      end else begin
         desc_valid_ff <= desc_valid_in;
         out_valid_ff  <= out_valid_in;
         idx_ff        <= idx_in;
         seg_ff        <= seg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctrl_ff   <= load_ctrl;
         a_slot_ff <= load_a_slot;
         b_slot_ff <= load_b_slot;
         span_ff   <= load_span;
      end
      if (issue) begin
         out_slot_ff  <= cur_slot;
         out_value_ff <= cur_value;
         out_last_ff  <= burst_end;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_slot  = out_slot_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

   a_busy_blocks_load: assert property (@(posedge clock) disable iff (reset)
      desc_valid_ff && !issue |-> !load_ready)
      else $error("new burst offered while the stored one still has writes");

   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      issue && burst_end |=> out_valid_ff && out_last_ff)
      else $error("final write of a burst not flagged");

   a_idx_in_span: assert property (@(posedge clock) disable iff (reset)
      desc_valid_ff |-> CNT_W'(idx_ff) < span_ff)
      else $error("slot counter ran past the segment length");

   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      load |-> load_span != '0)
      else $error("empty burst loaded");

endmodule

// ----- rtl/core/sound_level_light_driver.sv -----
// top level of the sound level light driver: registers, decode and chase state
//
// req_ch carries band levels (band_index, band_level in Q1.15); only the level of the
// band held in band_select is acted on, every other transfer is dropped silently.
// rsp_ch carries light writes (slot, light_value, last_write), one per transfer;
// last_write flags the final write caused by one level.
// a matching level is decoded in its accept cycle; any writes are stored as a burst:
//   follow: slot_count writes of the scaled level
//   peak:   slot_count writes of trip_value, then slot_count writes of 0
//   chase:  zero the old slot and light the next one, or one fade step
// the burst register takes the level at the req_ch transfer; the result register then
// takes each write from it, which can then transfer on rsp_ch.
// throughput: the burst sequencer gives one write per cycle unless stalled, so a burst
// holds req_ch until its last write issues; single-write and dropped levels go at one
// per cycle. while the receiver stalls the result register holds and the stored burst
// waits; one more level is taken once the stored burst has handed over its last write.
// reset clears the registers to their defaults (mode off, threshold 16384, trip value
// 255, one slot, band 0) and the chase position and fade level to zero.
// csr_* writes must only be made while no burst is in flight.
module sound_level_light_driver import sll_pkg::*; #(
   parameter int MAX_SLOTS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   sll_req_if.sink                req_ch,
   sll_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // slot index and slot count widths follow the slot list depth
   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   // configuration registers
   logic [1:0]              mode_ff;
   logic [LEVEL_W-1:0]      threshold_ff;
   logic [LIGHT_W-1:0]      trip_value_ff;
   logic [SLOT_COUNT_W-1:0] slot_count_ff;
   logic [BAND_W-1:0]       band_select_ff;

   // chase state
   logic [SLOT_W-1:0]       chase_pos_ff, chase_pos_in;
   logic [LIGHT_W-1:0]      fade_ff, fade_in;

   logic                    accept, match;
   logic [CNT_W-1:0]        n_slots;
   logic [SLOT_W-1:0]       pos_eff, pos_next;
   logic [CNT_W-1:0]        pos_inc;
   logic [LEVEL_W+LIGHT_W-1:0] scaled;
   logic [LIGHT_W:0]        follow_raw;
   logic [LIGHT_W-1:0]      follow_value;

   // burst handed to the sequencer
   logic                    load_valid, load_ready;
   burst_ctrl_type          load_ctrl;
   logic [SLOT_W-1:0]       load_a_slot, load_b_slot;
   logic [CNT_W-1:0]        load_span;

   logic [SLOT_W-1:0]       out_slot;
   logic [SLOT_W+OUT_SLOT_W-1:0] out_slot_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_OFF;
         threshold_ff   <= 16'd16384;
         trip_value_ff  <= FULL_LIGHT;
         slot_count_ff  <= 5'd1;
         band_select_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:        mode_ff        <= csr_wdata[1:0];
            CSR_THRESHOLD:   threshold_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_TRIP_VALUE:  trip_value_ff  <= csr_wdata[LIGHT_W-1:0];
            CSR_SLOT_COUNT:  slot_count_ff  <= csr_wdata[SLOT_COUNT_W-1:0];
            CSR_BAND_SELECT: band_select_ff <= csr_wdata[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   // a level is taken whenever the sequencer can take a new burst
   assign req_ch.ready = load_ready;
   assign accept = req_ch.valid && load_ready;
   assign match  = (req_ch.band_index == band_select_ff) && (mode_ff != MODE_OFF);

   // slot count clamped to 1..MAX_SLOTS
   always_comb begin
      if (slot_count_ff == '0) begin
         n_slots = CNT_W'(1);
      end else if (int'(slot_count_ff) > MAX_SLOTS) begin
         n_slots = CNT_W'(MAX_SLOTS);
      end else begin
         n_slots = CNT_W'(slot_count_ff);
      end
   end

   // a position left beyond the list by a smaller slot count restarts at zero
   assign pos_eff  = (CNT_W'(chase_pos_ff) >= n_slots) ? '0 : chase_pos_ff;
   assign pos_inc  = CNT_W'(pos_eff) + CNT_W'(1);
   assign pos_next = (pos_inc >= n_slots) ? '0 : SLOT_W'(pos_inc);

   // 255 * level / 32768, saturated for levels above full scale
   assign scaled       = {req_ch.band_level, {LIGHT_W{1'b0}}}
                         - {{LIGHT_W{1'b0}}, req_ch.band_level};
   assign follow_raw   = scaled[LEVEL_W+LIGHT_W-1:LEVEL_W-1];
   assign follow_value = follow_raw[LIGHT_W] ? FULL_LIGHT : follow_raw[LIGHT_W-1:0];

   always_comb begin
      load_valid        = 1'b0;
      load_ctrl.two_seg = 1'b0;
      load_ctrl.a_value = follow_value;
      load_ctrl.b_value = '0;
      load_a_slot       = '0;
      load_b_slot       = '0;
      load_span         = n_slots;
      chase_pos_in      = chase_pos_ff;
      fade_in           = fade_ff;
      case (mode_ff)
         MODE_FOLLOW: begin
            load_valid = match;
         end
         MODE_PEAK: begin
            // flash every slot, then blank every slot
            load_valid        = match && (req_ch.band_level >= threshold_ff);
            load_ctrl.two_seg = 1'b1;
            load_ctrl.a_value = trip_value_ff;
         end
         MODE_CHASE: begin
            load_span    = CNT_W'(1);
            load_a_slot  = pos_eff;
            chase_pos_in = pos_eff;
            if (req_ch.band_level > threshold_ff) begin
               // blank the old slot, light the next
               load_valid        = match;
               load_ctrl.two_seg = 1'b1;
               load_ctrl.a_value = '0;
               load_ctrl.b_value = trip_value_ff;
               load_b_slot       = pos_next;
               chase_pos_in      = pos_next;
               fade_in           = trip_value_ff;
            end else if (fade_ff != '0) begin
               // one fade step on the current slot
               load_valid        = match;
               load_ctrl.a_value = fade_ff - LIGHT_W'(1);
               fade_in           = fade_ff - LIGHT_W'(1);
            end
         end
         default: ;
      endcase
   end

   // chase state moves only on a matching level in chase mode
   always_ff @(posedge clock) begin
      if (reset) begin
         chase_pos_ff <= '0;
         fade_ff      <= '0;
      end else if (accept && match && (mode_ff == MODE_CHASE)) begin
         chase_pos_ff <= chase_pos_in;
         fade_ff      <= fade_in;
      end
   end

   sll_burst #(
      .SLOT_W (SLOT_W),
      .CNT_W  (CNT_W)
   ) u_burst (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (accept && load_valid),
      .load_ready  (load_ready),
      .load_ctrl   (load_ctrl),
      .load_a_slot (load_a_slot),
      .load_b_slot (load_b_slot),
      .load_span   (load_span),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_slot    (out_slot),
      .out_value   (rsp_ch.light_value),
      .out_last    (rsp_ch.last_write)
   );

   // slot port is four bits wide whatever the list depth
   assign out_slot_ext = {{OUT_SLOT_W{1'b0}}, out_slot};
   assign rsp_ch.slot  = out_slot_ext[OUT_SLOT_W-1:0];

endmodule

// ----- tb/sv/sll_light_checker.sv -----
// light write checker for the sound level light driver: mirrors registers, predicts and compares
module sll_light_checker import sll_pkg::*; #(
   parameter int MAX_SLOTS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [BAND_W-1:0]       req_band_index,
   input  logic [LEVEL_W-1:0]      req_band_level,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [OUT_SLOT_W-1:0]   rsp_slot,
   input  logic [LIGHT_W-1:0]      rsp_light_value,
   input  logic                    rsp_last_write,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      fail_count,
   output int                      pending_count
);

   typedef struct packed {
      logic [OUT_SLOT_W-1:0] slot;
      logic [LIGHT_W-1:0]    light_value;
      logic                  last_write;
   } light_write_type;

   logic [1:0]              cfg_mode;
   logic [LEVEL_W-1:0]      cfg_threshold;
   logic [LIGHT_W-1:0]      cfg_trip_value;
   logic [SLOT_COUNT_W-1:0] cfg_slot_count;
   logic [BAND_W-1:0]       cfg_band_select;
   logic [OUT_SLOT_W-1:0]   chase_slot;
   logic [LIGHT_W-1:0]      fade_value;
   light_write_type         expected_writes[$];

   task automatic queue_write(input int unsigned slot, input logic [LIGHT_W-1:0] value,
                              input logic is_last);
      light_write_type w;
      w.slot        = OUT_SLOT_W'(slot);
      w.light_value = value;
      w.last_write  = is_last;
      expected_writes.push_back(w);
   endtask

   // works out the burst of light writes caused by one level transfer
   task automatic predict_light_writes(input logic [BAND_W-1:0] band,
                                       input logic [LEVEL_W-1:0] level);
      int unsigned n;
      int unsigned scaled;
      int unsigned next_slot;
      if (band != cfg_band_select || cfg_mode == MODE_OFF) return;
      if (cfg_slot_count == 0) n = 1;
      else if (cfg_slot_count > MAX_SLOTS) n = MAX_SLOTS;
      else n = 32'(cfg_slot_count);
      case (cfg_mode)
         MODE_FOLLOW: begin
            scaled = (int'(FULL_LIGHT) * int'(level)) >> (LEVEL_W - 1);
            if (scaled > FULL_LIGHT) scaled = FULL_LIGHT;
            for (int unsigned s = 0; s < n; s++)
               queue_write(s, scaled[LIGHT_W-1:0], s == n - 1);
         end
         MODE_PEAK: begin
            if (level >= cfg_threshold) begin
               for (int unsigned s = 0; s < n; s++) queue_write(s, cfg_trip_value, 1'b0);
               for (int unsigned s = 0; s < n; s++) queue_write(s, '0, s == n - 1);
            end
         end
         MODE_CHASE: begin
            // a position left beyond a shrunk list restarts at slot zero
            if (chase_slot >= n) chase_slot = '0;
            if (level > cfg_threshold) begin
               queue_write(chase_slot, '0, 1'b0);
               next_slot = chase_slot + 1;
               if (next_slot >= n) next_slot = 0;
               chase_slot = OUT_SLOT_W'(next_slot);
               queue_write(chase_slot, cfg_trip_value, 1'b1);
               fade_value = cfg_trip_value;
            end else if (fade_value != 0) begin
               fade_value = fade_value - LIGHT_W'(1);
               queue_write(chase_slot, fade_value, 1'b1);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : monitor
      light_write_type got;
      light_write_type want;
      if (reset) begin
         cfg_mode        = MODE_OFF;
         cfg_threshold   = 16'd16384;
         cfg_trip_value  = FULL_LIGHT;
         cfg_slot_count  = 5'd1;
         cfg_band_select = '0;
         chase_slot      = '0;
         fade_value      = '0;
         expected_writes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:        cfg_mode        = csr_wdata[1:0];
               CSR_THRESHOLD:   cfg_threshold   = csr_wdata[LEVEL_W-1:0];
               CSR_TRIP_VALUE:  cfg_trip_value  = csr_wdata[LIGHT_W-1:0];
               CSR_SLOT_COUNT:  cfg_slot_count  = csr_wdata[SLOT_COUNT_W-1:0];
               CSR_BAND_SELECT: cfg_band_select = csr_wdata[BAND_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.slot        = rsp_slot;
            got.light_value = rsp_light_value;
            got.last_write  = rsp_last_write;
            if (expected_writes.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected light write, expected none,", $time,
                        " got slot %0d value %0d last %0b",
                        got.slot, got.light_value, got.last_write);
            end else begin
               want = expected_writes.pop_front();
               if (got.slot !== want.slot || got.light_value !== want.light_value ||
                   got.last_write !== want.last_write) begin
                  fail_count++;
                  $display("%0t: light write mismatch,", $time,
                           " expected slot %0d value %0d last %0b,",
                           want.slot, want.light_value, want.last_write,
                           " got slot %0d value %0d last %0b",
                           got.slot, got.light_value, got.last_write);
               end
            end
         end
         if (req_valid && req_ready) predict_light_writes(req_band_index, req_band_level);
      end
      pending_count = expected_writes.size();
   end

endmodule

// ----- tb/sv/tb_sound_level_light_driver.sv -----
// testbench top for the sound level light driver: clock, reset, stimulus, receiver and verdict
module tb_sound_level_light_driver;
   import sll_pkg::*;

   localparam int MAX_SLOTS      = 16;
   localparam int RESET_CYCLES   = 6;
   localparam int SETTLE_CYCLES  = 4;    // idle margin after draining, before register writes
   localparam int DRAIN_CYCLES   = 10;
   localparam int LONG_HOLD      = 300;  // receiver hold-off, long enough to back up the input
   localparam int WATCHDOG_LIMIT = 3000; // cycles without any transfer before giving up
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_LEVELS   = 31;   // selected-band levels per random phase

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     pending_count;
   int                     level_gap_pct;    // chance per cycle that the sender idles
   int                     write_stall_pct;  // chance per cycle that the receiver stalls
   logic                   long_hold_request;

   sll_req_if req_ch();
   sll_rsp_if rsp_ch();

   sound_level_light_driver #(.MAX_SLOTS(MAX_SLOTS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // watches both channels and the register port, keeps the expected light writes
   sll_light_checker #(.MAX_SLOTS(MAX_SLOTS)) light_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_band_index  (req_ch.band_index),
      .req_band_level  (req_ch.band_level),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_slot        (rsp_ch.slot),
      .rsp_light_value (rsp_ch.light_value),
      .rsp_last_write  (rsp_ch.last_write),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off when the stimulus asks for it
   initial begin
      logic long_hold_done;
      long_hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= write_stall_pct);
      end
   end

   // watchdog: counts cycles with no transfer on either channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: watchdog expired, %0d light writes still awaited", $time, pending_count);
      $display("tb_sound_level_light_driver: FAIL");
      $finish;
   end

   // one level transfer; entered and left at a falling edge, valid stays high on return
   // so that back-to-back levels need no second assignment in one step
   task automatic send_level(input logic [BAND_W-1:0] band, input logic [LEVEL_W-1:0] level);
      while ($urandom_range(99) < level_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.band_index <= band;
      req_ch.band_level <= level;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // drops valid and waits until every predicted light write has been seen
   task automatic drain_writes();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // idle point for register writes: drained, and a dropped level has left the pipeline
   task automatic settle();
      drain_writes();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [1:0] mode, input logic [LEVEL_W-1:0] threshold,
                                 input logic [LIGHT_W-1:0] trip_value,
                                 input logic [SLOT_COUNT_W-1:0] slot_count,
                                 input logic [BAND_W-1:0] band_select);
      write_register(CSR_MODE, CSR_DATA_W'(mode));
      write_register(CSR_THRESHOLD, threshold);
      write_register(CSR_TRIP_VALUE, CSR_DATA_W'(trip_value));
      write_register(CSR_SLOT_COUNT, CSR_DATA_W'(slot_count));
      write_register(CSR_BAND_SELECT, CSR_DATA_W'(band_select));
   endtask

   initial begin
      logic [1:0]              ph_mode;
      logic [LEVEL_W-1:0]      ph_threshold;
      logic [LIGHT_W-1:0]      ph_trip;
      logic [SLOT_COUNT_W-1:0] ph_slots;
      logic [BAND_W-1:0]       ph_band;
      logic [BAND_W-1:0]       band;
      logic [LEVEL_W-1:0]      level;
      int                      matched;

      // every input known from time zero
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_MODE;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.band_index = '0;
      req_ch.band_level = '0;
      level_gap_pct     = 0;
      write_stall_pct   = 0;
      long_hold_request = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part, no idling ----

      // out of reset the mode is off: a level on the selected band does nothing
      send_level(8'd0, 16'd32768);
      settle();

      // follow with a slot count of zero, clamped to one slot; zero, full scale and
      // above full scale (saturates at 255), then a level on another band
      write_register(CSR_MODE, CSR_DATA_W'(MODE_FOLLOW));
      write_register(CSR_SLOT_COUNT, 16'd0);
      send_level(8'd0, 16'd0);
      send_level(8'd0, 16'd32768);
      send_level(8'd0, 16'd65535);
      send_level(8'd5, 16'd100);
      settle();

      // slot count beyond the list clamps to sixteen slots; top band index
      write_register(CSR_SLOT_COUNT, 16'd31);
      write_register(CSR_BAND_SELECT, 16'd255);
      send_level(8'd255, 16'd16384);
      send_level(8'd255, 16'd1);
      send_level(8'd0, 16'd32768);
      settle();

      // peak: just below, at and above the threshold
      apply_settings(MODE_PEAK, 16'd32768, 8'd200, 5'd3, 8'd255);
      send_level(8'd255, 16'd32767);
      send_level(8'd255, 16'd32768);
      send_level(8'd255, 16'd65535);
      settle();
      // a zero threshold trips on a zero level
      write_register(CSR_THRESHOLD, 16'd0);
      send_level(8'd255, 16'd0);
      settle();

      // chase over four slots: no fade yet, a full lap with wrap, one fade step,
      // then three more trips to leave the position on the last slot
      apply_settings(MODE_CHASE, 16'd0, 8'd255, 5'd4, 8'd255);
      send_level(8'd255, 16'd0);
      repeat (4) send_level(8'd255, 16'd1);
      send_level(8'd255, 16'd0);
      repeat (3) send_level(8'd255, 16'd1);
      settle();

      // shrinking the list leaves the position out of range, so it restarts at zero
      write_register(CSR_SLOT_COUNT, 16'd2);
      send_level(8'd255, 16'd0);
      settle();

      // a round trip through follow keeps the chase state; then fade down to nothing
      write_register(CSR_MODE, CSR_DATA_W'(MODE_FOLLOW));
      write_register(CSR_MODE, CSR_DATA_W'(MODE_CHASE));
      write_register(CSR_TRIP_VALUE, 16'd1);
      send_level(8'd255, 16'd1);
      send_level(8'd255, 16'd0);
      send_level(8'd255, 16'd0);
      settle();

      // top threshold never trips; one below it trips with a zero trip value
      write_register(CSR_THRESHOLD, 16'd65535);
      write_register(CSR_TRIP_VALUE, 16'd0);
      send_level(8'd255, 16'd65535);
      settle();
      write_register(CSR_THRESHOLD, 16'd65534);
      send_level(8'd255, 16'd65535);
      settle();
      write_register(CSR_MODE, CSR_DATA_W'(MODE_OFF));
      send_level(8'd255, 16'd32768);
      settle();

      // ---- back-pressure: receiver holds off while full bursts keep coming ----
      apply_settings(MODE_FOLLOW, 16'd16384, 8'd255, 5'd16, 8'd7);
      long_hold_request = 1'b1;
      repeat (8) send_level(8'd7, 16'($urandom_range(65535)));

      // ---- random phases, each with its own settings and idling pattern ----
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case (phase % 4)
            0: begin
               level_gap_pct   = 0;
               write_stall_pct = 0;
            end
            1: begin
               level_gap_pct   = 74;
               write_stall_pct = 0;
            end
            2: begin
               level_gap_pct   = 0;
               write_stall_pct = 74;
            end
            default: begin
               level_gap_pct   = 9;
               write_stall_pct = 9;
            end
         endcase
         case (phase % 3)
            0:       ph_mode = MODE_FOLLOW;
            1:       ph_mode = MODE_PEAK;
            default: ph_mode = MODE_CHASE;
         endcase
         case ($urandom_range(3))
            0:       ph_threshold = 16'd0;
            1:       ph_threshold = 16'd32768;
            2:       ph_threshold = 16'($urandom_range(65535));
            default: ph_threshold = 16'($urandom_range(32768));
         endcase
         ph_trip = 8'($urandom_range(255));
         // mostly short channel lists, now and then anything the register holds
         if ($urandom_range(5) == 0) ph_slots = 5'($urandom_range(31));
         else ph_slots = 5'($urandom_range(4, 1));
         ph_band = 8'($urandom_range(255));
         apply_settings(ph_mode, ph_threshold, ph_trip, ph_slots, ph_band);

         matched = 0;
         while (matched < PHASE_LEVELS) begin
            // a quarter of the levels go to a random band; those on other bands must be ignored
            if ($urandom_range(3) == 0) band = 8'($urandom_range(255));
            else band = ph_band;
            // levels cluster around the threshold and the ends of the scale
            case ($urandom_range(5))
               0:       level = 16'($urandom_range(65535));
               1:       level = ph_threshold + 16'($urandom_range(4)) - 16'd2;
               2:       level = 16'd0;
               3:       level = 16'd32768;
               4:       level = 16'($urandom_range(32768));
               default: level = 16'd65535;
            endcase
            send_level(band, level);
            if (band == ph_band) begin
               matched++;
               // sender pauses once mid-phase until every write has come back
               if (phase == 5 && matched == PHASE_LEVELS / 2) drain_writes();
            end
         end
      end

      drain_writes();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_sound_level_light_driver: PASS");
      else
         $display("tb_sound_level_light_driver: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/sll_pkg.sv
rtl/core/sll_req_if.sv
rtl/core/sll_burst.sv
rtl/core/sound_level_light_driver.sv
tb/sv/sll_light_checker.sv
tb/sv/tb_sound_level_light_driver.sv
